// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file cbra_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CBRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CBRA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cbra_pkg.sv =====
// constants and types of the cluster bitmap run allocator
// no dependencies
package cbra_pkg;

    localparam int MAX_CLUSTERS = 32768;
    localparam int WORD_BITS    = 32;
    localparam int WORDS        = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = $clog2(WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int RUN_W        = BIT_W + 1;
    localparam int IDX_W        = ADDR_W + BIT_W;
    localparam int CNT_W        = 16;
    localparam int CL_W         = 15;
    localparam int EW           = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(32768);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
        logic [RUN_W-1:0] claim;
        logic             run_end;
    } t_scan_res;

endpackage

// ===== hdl/cbra_scan.sv =====
// one-word first-fit scan: finds the free run in a bitmap word and marks it
// depends on cbra_pkg
module cbra_scan (
    input  logic [cbra_pkg::WORD_BITS-1:0] i_word,
    input  logic [cbra_pkg::ADDR_W-1:0]    i_addr,
    input  logic [cbra_pkg::EW-1:0]        i_total,
    input  logic                           i_search,
    input  logic [cbra_pkg::EW-1:0]        i_need,
    output logic [cbra_pkg::WORD_BITS-1:0] o_word,
    output cbra_pkg::t_scan_res            o_res
);
    import cbra_pkg::*;

    logic [EW-1:0]        base;
    logic [EW-1:0]        rem;
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] used;
    logic [WORD_BITS-1:0] free_sh;
    logic [WORD_BITS-1:0] mk;
    logic [BIT_W-1:0]     fz;
    logic [BIT_W-1:0]     p;
    logic [RUN_W-1:0]     run;
    logic [RUN_W-1:0]     k;

    always_comb begin
        base = EW'({i_addr, BIT_W'(0)});
        rem  = i_total - base;
        for (int j = 0; j < WORD_BITS; j++) begin
            lim[j] = (EW'(j) < rem);
        end
        used = i_word | ~lim;

        fz = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!used[j]) begin
                fz = BIT_W'(j);
            end
        end
        p = i_search ? fz : '0;

        free_sh = (~used) >> p;
        run = RUN_W'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!free_sh[j]) begin
                run = RUN_W'(j);
            end
        end

        k = (i_need < EW'(run)) ? RUN_W'(i_need) : run;
        if (i_search && (&used)) begin
            k = '0;
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            mk[j] = (RUN_W'(j) < k);
        end

        o_word        = i_word | (mk << p);
        o_res.hit     = ~&used;
        o_res.pos     = fz;
        o_res.claim   = k;
        o_res.run_end = ((RUN_W'(p) + run) == RUN_W'(WORD_BITS)) && (k == run);
    end

endmodule

// ===== hdl/cluster_bitmap_run_allocator_core.sv =====
// top level of the cluster bitmap run allocator: bitmap memory and sequencer
// depends on cbra_pkg and cbra_scan
//
// Request channel: an item is taken at a clock edge with start high and busy
// low. i_cmd selects allocate (first-fit run from cluster 0) or free (clear
// i_cluster_count bits from i_first_cluster).
// Result channel: o_done is high for exactly one cycle with o_run_start,
// o_run_length, o_allocated_total and o_rejected. The receiver cannot stall;
// a result must be taken in its cycle.
// Configuration: i_cfg_we writes i_cfg_wdata into the cluster total; write it
// only while busy is low and no result is pending.
// Timing: the bitmap is one memory of 1024 words of 32 bits with one read and
// one write a cycle. A walk visits its words one after another (read of the next
// word overlaps the write-back of the current one). An allocate scans words from
// word 0 up to the end of the run; a free visits every word the range touches.
// A rejected free, an allocate of zero or a zero total is answered from idle
// without a word walk. Items are handled one at a time; busy is high while a
// word walk runs.
// Reset: synchronous and active low; afterwards a clearing pass writes every
// bitmap word to zero with busy high. Configuration writes are taken during
// that pass.
module cluster_bitmap_run_allocator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [cbra_pkg::CL_W-1:0]  i_first_cluster,
    input  logic [cbra_pkg::CNT_W-1:0] i_cluster_count,
    input  logic                       i_cfg_we,
    input  logic [cbra_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output logic [cbra_pkg::CL_W-1:0]  o_run_start,
    output logic [cbra_pkg::CNT_W-1:0] o_run_length,
    output logic [cbra_pkg::CNT_W-1:0] o_allocated_total,
    output logic                       o_rejected
);
    import cbra_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ALLOC, S_FREE} t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [EW-1:0]     r_len, n_len;
    logic [EW-1:0]     r_count, n_count;
    logic [IDX_W-1:0]  r_start, n_start;
    logic [EW-1:0]     r_alloc, n_alloc;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [BIT_W-1:0]  r_lo, n_lo;
    logic [ADDR_W-1:0] r_last_word, n_last_word;
    logic [BIT_W-1:0]  r_last_bit, n_last_bit;
    logic              r_done, n_done;
    logic [CL_W-1:0]   r_run_start, n_run_start;
    logic [CNT_W-1:0]  r_run_length, n_run_length;
    logic              r_rejected, n_rejected;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 we;
    logic [ADDR_W-1:0]    wa;
    logic [WORD_BITS-1:0] wd;

    logic [EW-1:0]        eff_total;
    logic [EW-1:0]        fe;
    logic [EW-1:0]        last;
    logic [EW-1:0]        len_n;
    logic [EW-1:0]        nb;
    logic [IDX_W-1:0]     start_n;
    logic                 more;
    logic                 go;
    logic [WORD_BITS-1:0] fmask;
    logic [WORD_BITS-1:0] scan_word;
    t_scan_res            res;

    assign eff_total = (EW'(r_total) > EW'(MAX_CLUSTERS)) ? EW'(MAX_CLUSTERS) : EW'(r_total);

    cbra_scan u_scan (
        .i_word   (r_rdata),
        .i_addr   (r_addr),
        .i_total  (eff_total),
        .i_search (r_len == '0),
        .i_need   (r_count - r_len),
        .o_word   (scan_word),
        .o_res    (res)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_addr       = r_addr;
        n_len        = r_len;
        n_count      = r_count;
        n_start      = r_start;
        n_alloc      = r_alloc;
        n_total      = r_total;
        n_lo         = r_lo;
        n_last_word  = r_last_word;
        n_last_bit   = r_last_bit;
        n_done       = 1'b0;
        n_run_start  = r_run_start;
        n_run_length = r_run_length;
        n_rejected   = r_rejected;

        rd_addr = r_addr + 1'b1;
        we      = 1'b0;
        wa      = r_addr;
        wd      = scan_word;

        fe      = EW'(i_first_cluster);
        last    = fe + EW'(i_cluster_count) - 1'b1;
        len_n   = r_len + EW'(res.claim);
        start_n = (r_len == '0) ? {r_addr, res.pos} : r_start;
        nb      = EW'({r_addr, BIT_W'(0)}) + EW'(WORD_BITS);
        more    = res.run_end && (len_n < r_count);
        go      = (nb < eff_total) && ((r_len == '0) ? (!res.hit || more) : more);
        for (int j = 0; j < WORD_BITS; j++) begin
            fmask[j] = (BIT_W'(j) >= r_lo)
                     && ((r_addr != r_last_word) || (BIT_W'(j) <= r_last_bit));
        end

        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                wd    = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = (i_cmd == CMD_FREE) ? fe[BIT_W +: ADDR_W] : '0;
                if (start) begin
                    n_run_start  = '0;
                    n_run_length = '0;
                    n_rejected   = 1'b0;
                    if (i_cmd == CMD_FREE) begin
                        if ((i_cluster_count == '0)
                                || (EW'(i_cluster_count) > r_alloc)
                                || ((fe + EW'(i_cluster_count)) > eff_total)) begin
                            n_done     = 1'b1;
                            n_rejected = 1'b1;
                        end else begin
                            n_alloc     = r_alloc - EW'(i_cluster_count);
                            n_addr      = fe[BIT_W +: ADDR_W];
                            n_lo        = fe[BIT_W-1:0];
                            n_last_word = last[BIT_W +: ADDR_W];
                            n_last_bit  = last[BIT_W-1:0];
                            n_state     = S_FREE;
                        end
                    end else begin
                        if ((i_cluster_count == '0) || (eff_total == '0)) begin
                            n_done = 1'b1;
                        end else begin
                            n_addr  = '0;
                            n_len   = '0;
                            n_count = EW'(i_cluster_count);
                            n_state = S_ALLOC;
                        end
                    end
                end
            end
            S_ALLOC: begin
                we      = 1'b1;
                n_len   = len_n;
                n_start = start_n;
                n_alloc = r_alloc + EW'(res.claim);
                if (go) begin
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                    n_run_length = CNT_W'(len_n);
                    n_run_start  = (len_n == '0) ? '0 : CL_W'(start_n);
                end
            end
            S_FREE: begin
                we = 1'b1;
                wd = r_rdata & ~fmask;
                if (r_addr == r_last_word) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_lo   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_total = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_alloc <= '0;
            r_total <= TOTAL_RST;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_alloc <= n_alloc;
            r_total <= n_total;
            r_done  <= n_done;
        end
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_count      <= n_count;
        r_start      <= n_start;
        r_lo         <= n_lo;
        r_last_word  <= n_last_word;
        r_last_bit   <= n_last_bit;
        r_run_start  <= n_run_start;
        r_run_length <= n_run_length;
        r_rejected   <= n_rejected;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_run_start       = r_run_start;
    assign o_run_length      = r_run_length;
    assign o_allocated_total = CNT_W'(r_alloc);
    assign o_rejected        = r_rejected;

endmodule

// ===== hdl/cbra_checker.sv =====
// port-level checks on the cluster bitmap run allocator, bound to the top level
// depends on cbra_pkg and assert_macros.svh
`include "assert_macros.svh"

module cbra_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       o_done,
    input  logic [cbra_pkg::CL_W-1:0]  o_run_start,
    input  logic [cbra_pkg::CNT_W-1:0] o_run_length,
    input  logic                       o_rejected
);
    import cbra_pkg::*;

    // reset starts the clearing pass and drops any pending result
    `CBRA_ASSERT_NR(a_rst_busy, i_clk, !i_rst_n |=> busy, "busy low after reset")
    `CBRA_ASSERT_NR(a_rst_done, i_clk, !i_rst_n |=> !o_done, "result strobe after reset")
    // a result only follows a request or running work
    `CBRA_ASSERT(a_done_cause, i_clk, i_rst_n, o_done |-> $past(start || busy), "result without request")
    // an empty run reports start zero
    `CBRA_ASSERT(a_empty_run, i_clk, i_rst_n, (o_done && (o_run_length == '0)) |-> (o_run_start == '0), "empty run with nonzero start")
    // a refused free allocates nothing
    `CBRA_ASSERT(a_rej_run, i_clk, i_rst_n, (o_done && o_rejected) |-> (o_run_length == '0), "rejected request with a run")

endmodule

bind cluster_bitmap_run_allocator_core cbra_checker u_cbra_checker (.*);

// ===== dv/cluster_bitmap_run_allocator_core_test.sv =====
// self-checking testbench of cluster_bitmap_run_allocator_core: directed edge cases, then
// random allocate and free traffic under several cluster totals and sender idle rates
// depends on cbra_pkg and the core; a bitmap predictor in this file computes every result
module cluster_bitmap_run_allocator_core_test;
    import cbra_pkg::*;

    localparam int unsigned STALL_LIMIT = 8000;
    localparam int unsigned DRAIN_CYCLES = 1100;

    typedef struct packed {
        logic [CL_W-1:0]  run_start;
        logic [CNT_W-1:0] run_length;
        logic [CNT_W-1:0] allocated_total;
        logic             rejected;
    } t_alloc_result;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } t_cluster_run;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_cmd = CMD_ALLOC;
    logic [CL_W-1:0]  i_first_cluster = '0;
    logic [CNT_W-1:0] i_cluster_count = '0;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             o_done;
    logic [CL_W-1:0]  o_run_start;
    logic [CNT_W-1:0] o_run_length;
    logic [CNT_W-1:0] o_allocated_total;
    logic             o_rejected;

    // predictor state
    bit               cluster_used [MAX_CLUSTERS];
    int unsigned      alloc_count = 0;
    logic [CNT_W-1:0] pred_total = TOTAL_RST;

    t_alloc_result    pending_results [$];
    t_cluster_run     live_runs [$];
    int               idle_pct = 0;
    int               mismatch_count = 0;

    cluster_bitmap_run_allocator_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_first_cluster   (i_first_cluster),
        .i_cluster_count   (i_cluster_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_done            (o_done),
        .o_run_start       (o_run_start),
        .o_run_length      (o_run_length),
        .o_allocated_total (o_allocated_total),
        .o_rejected        (o_rejected)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alloc_result predict_request(input logic cmd,
                                                      input logic [CL_W-1:0] first,
                                                      input logic [CNT_W-1:0] count);
        t_alloc_result res;
        int unsigned   lim;
        int unsigned   len;
        int unsigned   idx;
        int unsigned   run_first;
        int unsigned   cnt;
        int unsigned   fst;
        lim = 32'(pred_total);
        if (lim > MAX_CLUSTERS) lim = MAX_CLUSTERS;
        cnt = 32'(count);
        fst = 32'(first);
        len = 0;
        run_first = 0;
        res.rejected = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (cnt != 0) begin
                idx = 0;
                while (idx < lim && len < cnt) begin
                    if (!cluster_used[idx]) begin
                        if (len == 0) run_first = idx;
                        cluster_used[idx] = 1'b1;
                        len++;
                        alloc_count++;
                    end else if (len != 0) begin
                        break;
                    end
                    idx++;
                end
            end
        end else if (cnt == 0 || cnt > alloc_count || fst + cnt > lim) begin
            res.rejected = 1'b1;
        end else begin
            for (idx = 0; idx < cnt; idx++) cluster_used[fst + idx] = 1'b0;
            alloc_count -= cnt;
        end
        res.run_start = run_first[CL_W-1:0];
        res.run_length = len[CNT_W-1:0];
        res.allocated_total = alloc_count[CNT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display({"%0t unexpected result: expected none ",
                          "actual start %0d length %0d total %0d rejected %0b"},
                         $time, o_run_start, o_run_length, o_allocated_total, o_rejected);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("run_start", 32'(want.run_start), 32'(o_run_start));
                check_field("run_length", 32'(want.run_length), 32'(o_run_length));
                check_field("allocated_total", 32'(want.allocated_total),
                            32'(o_allocated_total));
                check_field("rejected", 32'(want.rejected), 32'(o_rejected));
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_done) quiet = 0;
            else quiet++;
        end
        $display("cluster_bitmap_run_allocator_core_test NOT OK");
        $finish;
    end

    task automatic send_request(input logic cmd, input int unsigned first,
                                input int unsigned count);
        t_alloc_result res;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_first_cluster <= first[CL_W-1:0];
        i_cluster_count <= count[CNT_W-1:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = predict_request(cmd, first[CL_W-1:0], count[CNT_W-1:0]);
        pending_results.push_back(res);
        if (cmd == CMD_ALLOC && res.run_length != 0)
            live_runs.push_back('{32'(res.run_start), 32'(res.run_length)});
    endtask

    task automatic write_cluster_total(input logic [CNT_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        pred_total = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic release_live_runs();
        t_cluster_run run;
        while (live_runs.size() != 0) begin
            run = live_runs.pop_front();
            send_request(CMD_FREE, run.first, run.count);
        end
    endtask

    task automatic test_alloc_free_edges();
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 32767, 1);
        send_request(CMD_ALLOC, 0, 32768);
        // bitmap full
        send_request(CMD_ALLOC, 0, 1);
        send_request(CMD_ALLOC, 0, 65535);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 32767, 2);
        send_request(CMD_FREE, 32767, 1);
        send_request(CMD_FREE, 0, 32768);
        send_request(CMD_FREE, 0, 32767);
        send_request(CMD_ALLOC, 0, 65535);
        send_request(CMD_FREE, 0, 32768);
        // run stops at a used cluster, then a free over clusters already free
        send_request(CMD_ALLOC, 0, 8);
        send_request(CMD_ALLOC, 0, 4);
        send_request(CMD_FREE, 4, 4);
        send_request(CMD_ALLOC, 0, 10);
        send_request(CMD_FREE, 20, 4);
        send_request(CMD_FREE, 0, 12);
        send_request(CMD_FREE, 0, 8);
        send_request(CMD_ALLOC, 0, 16);
        send_request(CMD_FREE, 0, 16);
        send_request(CMD_FREE, 0, 8);
        live_runs.delete();
    endtask

    task automatic test_total_extremes();
        write_cluster_total(16'd0);
        send_request(CMD_ALLOC, 0, 5);
        send_request(CMD_FREE, 0, 1);
        send_request(CMD_FREE, 0, 0);
        write_cluster_total(16'd1);
        send_request(CMD_ALLOC, 0, 3);
        send_request(CMD_ALLOC, 0, 1);
        send_request(CMD_FREE, 0, 1);
        send_request(CMD_FREE, 1, 1);
        // above the bitmap size, clamped
        write_cluster_total(16'hFFFF);
        send_request(CMD_ALLOC, 0, 2);
        send_request(CMD_FREE, 32767, 2);
        send_request(CMD_FREE, 0, 2);
        live_runs.delete();
    endtask

    task automatic test_mixed_traffic(input logic [CNT_W-1:0] total, input int idle,
                                      input int items);
        int unsigned  lim;
        int unsigned  roll;
        int unsigned  pick;
        int unsigned  n;
        t_cluster_run run;
        release_live_runs();
        write_cluster_total(total);
        idle_pct = idle;
        lim = 32'(total);
        if (lim > MAX_CLUSTERS) lim = MAX_CLUSTERS;
        repeat (items) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(64);
                send_request(1'($urandom_range(1)), $urandom_range(32767), n);
            end else if (roll < 45 && live_runs.size() != 0) begin
                pick = $urandom_range(live_runs.size() - 1);
                run = live_runs[pick];
                n = ($urandom_range(3) == 0) ? $urandom_range(1, run.count) : run.count;
                if (n == run.count) begin
                    live_runs.delete(pick);
                end else begin
                    live_runs[pick].first = run.first + n;
                    live_runs[pick].count = run.count - n;
                end
                send_request(CMD_FREE, run.first, n);
            end else begin
                roll = $urandom_range(99);
                if (roll < 70) n = $urandom_range(1, 8);
                else if (roll < 92) n = $urandom_range(1, 64);
                else if (roll < 97) n = $urandom_range(1, lim);
                else n = 0;
                send_request(CMD_ALLOC, $urandom_range(32767), n);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_alloc_free_edges();
        test_total_extremes();
        test_mixed_traffic(16'd64, 0, 150);
        test_mixed_traffic(16'($urandom_range(100, 700)), 63, 150);
        test_mixed_traffic(16'hFFFF, 38, 120);
        test_mixed_traffic(16'd1, 0, 30);
        test_mixed_traffic(16'($urandom_range(1, 65535)), 0, 110);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("cluster_bitmap_run_allocator_core_test OK");
        end else begin
            $display("cluster_bitmap_run_allocator_core_test NOT OK");
        end
        $finish;
    end

endmodule
